@@ rtl/unicode_range_text_parser_unit_defines.svh @@
// assertion macros used by the range text parser rtl
`ifndef UNICODE_RANGE_TEXT_PARSER_UNIT_DEFINES_SVH
`define UNICODE_RANGE_TEXT_PARSER_UNIT_DEFINES_SVH

// condition in this cycle implies consequence in the next cycle
`define URTP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// condition implies consequence in the same cycle
`define URTP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/urtp_pkg.sv @@
// types and constants of the unicode range text parser
package urtp_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned POINT_W = 21;

  localparam logic [POINT_W-1:0] MAX_CODE_POINT = 21'h10FFFF;

  localparam logic [CHAR_W-1:0] CH_PLUS     = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_QUESTION = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_MINUS    = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UPPER_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LOWER_F  = 8'h66;

  // parser phase, one-hot
  typedef enum logic [4:0] {
    PH_PLUS  = 5'b00001,
    PH_START = 5'b00010,
    PH_WILD  = 5'b00100,
    PH_END   = 5'b01000,
    PH_BAD   = 5'b10000
  } phase_t;

endpackage

@@ rtl/urtp_char_if.sv @@
// character channel: one text byte per word with an end flag
interface urtp_char_if;
  logic                         valid;
  logic                         ready;
  logic [urtp_pkg::CHAR_W-1:0]  ch;
  logic                         end_of_text;

  modport source (output valid, output ch, output end_of_text, input ready);
  modport sink (input valid, input ch, input end_of_text, output ready);
endinterface

@@ rtl/urtp_range_if.sv @@
// range channel: validity flag and first and last code points
interface urtp_range_if;
  logic                          valid;
  logic                          ready;
  logic                          valid_res;
  logic [urtp_pkg::POINT_W-1:0]  range_first;
  logic [urtp_pkg::POINT_W-1:0]  range_last;

  modport source (output valid, output valid_res, output range_first, output range_last,
                  input ready);
  modport sink (input valid, input valid_res, input range_first, input range_last,
                output ready);
endinterface

@@ rtl/unicode_range_text_parser_unit.sv @@
// unicode range text parser: byte stream in, one range word per text out
//
//  channel  dir  modport  payload                             word
//  -------  ---  -------  ----------------------------------  -----------------------
//  text     in   sink     ch[7:0], end_of_text                one byte of range text
//  result   out  source   valid_res, range_first, range_last  one per end_of_text byte
//
//  one byte is taken per cycle; the parse state and the finished range are
//  both updated at the edge that takes the byte
//  the range word of a final byte is offered from the cycle after that edge
//  text.ready is low only while the result register holds an untaken word
//  and result.ready is low; a taken result frees it in the same cycle
//  rst (synchronous, active high) empties the result register and returns
//  the parser to waiting for the plus sign
`include "unicode_range_text_parser_unit_defines.svh"

module unicode_range_text_parser_unit #(
  parameter int unsigned MAX_DIGITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  urtp_char_if.sink   text,
  urtp_range_if.source result
);

  localparam int unsigned ACC_W = 4 * MAX_DIGITS;
  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned SH_W  = CNT_W + 2;
  // wide enough for any accumulator and for the code point limit
  localparam int unsigned CMP_W = ACC_W + urtp_pkg::POINT_W;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

  // parse state
  urtp_pkg::phase_t  phase, phase_next, phase_adv;
  logic [ACC_W-1:0]  first_accum, first_accum_next, first_accum_adv;
  logic [ACC_W-1:0]  last_accum, last_accum_next, last_accum_adv;
  logic [CNT_W-1:0]  start_cnt, start_cnt_next, start_cnt_adv;
  logic [CNT_W-1:0]  wild_cnt, wild_cnt_next, wild_cnt_adv;
  logic [CNT_W-1:0]  end_cnt, end_cnt_next, end_cnt_adv;

  // result register
  logic                          res_valid;
  logic                          res_ok;
  logic [urtp_pkg::POINT_W-1:0]  res_first;
  logic [urtp_pkg::POINT_W-1:0]  res_last;

  logic        take;
  logic        is_hex;
  logic [3:0]  hex_val;
  logic [CNT_W:0] total_cnt;

  // range evaluation
  logic [SH_W-1:0]   wild_sh;
  logic [CMP_W-1:0]  first_ext, last_ext, wild_mask;
  logic [CMP_W-1:0]  lo, hi;
  logic              form_ok, range_ok;

  assign take       = text.valid && text.ready;
  assign text.ready = !res_valid || result.ready;

  // hex digit decode, either case
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (text.ch >= urtp_pkg::CH_ZERO && text.ch <= urtp_pkg::CH_NINE) begin
      hex_val = 4'(text.ch - urtp_pkg::CH_ZERO);
    end else if (text.ch >= urtp_pkg::CH_LOWER_A && text.ch <= urtp_pkg::CH_LOWER_F) begin
      hex_val = 4'(text.ch - urtp_pkg::CH_LOWER_A + 8'd10);
    end else if (text.ch >= urtp_pkg::CH_UPPER_A && text.ch <= urtp_pkg::CH_UPPER_F) begin
      hex_val = 4'(text.ch - urtp_pkg::CH_UPPER_A + 8'd10);
    end else begin
      is_hex = 1'b0;
    end
  end

  assign total_cnt = {1'b0, start_cnt} + {1'b0, wild_cnt};

  // grammar step for the incoming byte
  always_comb begin
    phase_adv       = phase;
    first_accum_adv = first_accum;
    last_accum_adv  = last_accum;
    start_cnt_adv   = start_cnt;
    wild_cnt_adv    = wild_cnt;
    end_cnt_adv     = end_cnt;
    case (phase)
      urtp_pkg::PH_PLUS: begin
        phase_adv = (text.ch == urtp_pkg::CH_PLUS) ? urtp_pkg::PH_START : urtp_pkg::PH_BAD;
      end
      urtp_pkg::PH_START: begin
        if (is_hex && start_cnt < MAX_CNT) begin
          first_accum_adv = (first_accum << 4) | ACC_W'(hex_val);
          start_cnt_adv   = start_cnt + 1'b1;
        end else if (text.ch == urtp_pkg::CH_QUESTION && start_cnt < MAX_CNT) begin
          wild_cnt_adv = CNT_W'(1);
          phase_adv    = urtp_pkg::PH_WILD;
        end else if (text.ch == urtp_pkg::CH_MINUS && start_cnt != '0) begin
          phase_adv = urtp_pkg::PH_END;
        end else begin
          phase_adv = urtp_pkg::PH_BAD;
        end
      end
      urtp_pkg::PH_WILD: begin
        if (text.ch == urtp_pkg::CH_QUESTION && total_cnt < {1'b0, MAX_CNT}) begin
          wild_cnt_adv = wild_cnt + 1'b1;
        end else begin
          phase_adv = urtp_pkg::PH_BAD;
        end
      end
      urtp_pkg::PH_END: begin
        if (is_hex && end_cnt < MAX_CNT) begin
          last_accum_adv = (last_accum << 4) | ACC_W'(hex_val);
          end_cnt_adv    = end_cnt + 1'b1;
        end else begin
          phase_adv = urtp_pkg::PH_BAD;
        end
      end
      default: begin
        phase_adv = urtp_pkg::PH_BAD;
      end
    endcase
  end

  // the final byte of a text returns the parser to its start
  always_comb begin
    phase_next       = phase;
    first_accum_next = first_accum;
    last_accum_next  = last_accum;
    start_cnt_next   = start_cnt;
    wild_cnt_next    = wild_cnt;
    end_cnt_next     = end_cnt;
    if (take) begin
      if (text.end_of_text) begin
        phase_next       = urtp_pkg::PH_PLUS;
        first_accum_next = '0;
        last_accum_next  = '0;
        start_cnt_next   = '0;
        wild_cnt_next    = '0;
        end_cnt_next     = '0;
      end else begin
        phase_next       = phase_adv;
        first_accum_next = first_accum_adv;
        last_accum_next  = last_accum_adv;
        start_cnt_next   = start_cnt_adv;
        wild_cnt_next    = wild_cnt_adv;
        end_cnt_next     = end_cnt_adv;
      end
    end
  end

  // range from the state after this byte; wildcards pad start with 0, end with F
  assign wild_sh   = {wild_cnt_adv, 2'b00};
  assign first_ext = {{urtp_pkg::POINT_W{1'b0}}, first_accum_adv};
  assign last_ext  = {{urtp_pkg::POINT_W{1'b0}}, last_accum_adv};
  assign wild_mask = ~({CMP_W{1'b1}} << wild_sh);

  always_comb begin
    form_ok = 1'b0;
    lo      = '0;
    hi      = '0;
    case (phase_adv)
      urtp_pkg::PH_START: begin
        form_ok = (start_cnt_adv != '0);
        lo      = first_ext;
        hi      = first_ext;
      end
      urtp_pkg::PH_WILD: begin
        form_ok = 1'b1;
        lo      = first_ext << wild_sh;
        hi      = (first_ext << wild_sh) | wild_mask;
      end
      urtp_pkg::PH_END: begin
        form_ok = (end_cnt_adv != '0);
        lo      = first_ext;
        hi      = last_ext;
      end
      default: begin
        form_ok = 1'b0;
      end
    endcase
  end

  assign range_ok = form_ok && (lo <= hi) &&
                    (hi <= CMP_W'(urtp_pkg::MAX_CODE_POINT));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= urtp_pkg::PH_PLUS;
      first_accum <= '0;
      last_accum  <= '0;
      start_cnt   <= '0;
      wild_cnt    <= '0;
      end_cnt     <= '0;
    end else begin
      phase       <= phase_next;
      first_accum <= first_accum_next;
      last_accum  <= last_accum_next;
      start_cnt   <= start_cnt_next;
      wild_cnt    <= wild_cnt_next;
      end_cnt     <= end_cnt_next;
    end
  end

  // output word valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (take && text.end_of_text) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  // output payload, zero fields on a bad range
  always_ff @(posedge clk) begin
    if (take && text.end_of_text) begin
      res_ok    <= range_ok;
      res_first <= range_ok ? lo[urtp_pkg::POINT_W-1:0] : '0;
      res_last  <= range_ok ? hi[urtp_pkg::POINT_W-1:0] : '0;
    end
  end

  assign result.valid       = res_valid;
  assign result.valid_res   = res_ok;
  assign result.range_first = res_first;
  assign result.range_last  = res_last;

  // checks
  `URTP_ASSERT_NEXT(a_final_gives_word, clk, rst, take && text.end_of_text, res_valid, "final byte gave no result word")
  `URTP_ASSERT_NEXT(a_inner_no_word, clk, rst, take && !text.end_of_text && (result.ready || !res_valid), !res_valid, "result word without a final byte")
  `URTP_ASSERT_NEXT(a_final_resets_phase, clk, rst, take && text.end_of_text, phase == urtp_pkg::PH_PLUS, "parser not back at start after final byte")
  `URTP_ASSERT_NOW(a_bad_is_zero, clk, rst, res_valid && !res_ok, res_first == '0 && res_last == '0, "bad range carries non-zero code points")
  `URTP_ASSERT_NOW(a_good_is_ordered, clk, rst, res_valid && res_ok, res_first <= res_last && res_last <= urtp_pkg::MAX_CODE_POINT, "legal range out of order or above limit")

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the unicode range text parser unit
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_DIGITS    = 6;
  localparam int RANDOM_ITEMS  = 1200;  // bytes of random text to offer
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES  = 8;     // settle time after the last range word
  localparam int STALL_LIMIT   = 2000;  // cycles with no word moving on either side

  // one expected range word
  typedef struct packed {
    logic                         legal;
    logic [urtp_pkg::POINT_W-1:0] lo_point;
    logic [urtp_pkg::POINT_W-1:0] hi_point;
  } range_word_t;

  // parse model plus the queue of range words still to arrive
  class range_checker;
    range_word_t      pending_ranges[$];
    urtp_pkg::phase_t phase;
    logic [31:0]      first_acc;
    logic [31:0]      last_acc;
    int unsigned      n_start;
    int unsigned      n_wild;
    int unsigned      n_end;
    int               n_checked;
    int               n_legal;
    int               errors;
    int               reported;

    function new();
      n_checked = 0;
      n_legal   = 0;
      errors    = 0;
      reported  = 0;
      restart();
    endfunction

    function void restart();
      phase     = urtp_pkg::PH_PLUS;
      first_acc = '0;
      last_acc  = '0;
      n_start   = 0;
      n_wild    = 0;
      n_end     = 0;
    endfunction

    function int nibble_of(logic [urtp_pkg::CHAR_W-1:0] c);
      if (c >= urtp_pkg::CH_ZERO && c <= urtp_pkg::CH_NINE)
        return int'(c - urtp_pkg::CH_ZERO);
      if (c >= urtp_pkg::CH_LOWER_A && c <= urtp_pkg::CH_LOWER_F)
        return int'(c - urtp_pkg::CH_LOWER_A) + 10;
      if (c >= urtp_pkg::CH_UPPER_A && c <= urtp_pkg::CH_UPPER_F)
        return int'(c - urtp_pkg::CH_UPPER_A) + 10;
      return -1;
    endfunction

    // one accepted text byte; the final byte queues the range word it yields
    function void take_char(logic [urtp_pkg::CHAR_W-1:0] c, logic eot);
      int          h;
      logic        ok;
      logic [31:0] lo;
      logic [31:0] hi;
      range_word_t w;
      h = nibble_of(c);
      case (phase)
        urtp_pkg::PH_PLUS: begin
          phase = (c == urtp_pkg::CH_PLUS) ? urtp_pkg::PH_START : urtp_pkg::PH_BAD;
        end
        urtp_pkg::PH_START: begin
          if (h >= 0 && n_start < MAX_DIGITS) begin
            first_acc = (first_acc << 4) | 32'(h[3:0]);
            n_start++;
          end else if (c == urtp_pkg::CH_QUESTION && n_start < MAX_DIGITS) begin
            n_wild = 1;
            phase  = urtp_pkg::PH_WILD;
          end else if (c == urtp_pkg::CH_MINUS && n_start > 0) begin
            phase = urtp_pkg::PH_END;
          end else begin
            phase = urtp_pkg::PH_BAD;
          end
        end
        urtp_pkg::PH_WILD: begin
          if (c == urtp_pkg::CH_QUESTION && n_start + n_wild < MAX_DIGITS) n_wild++;
          else phase = urtp_pkg::PH_BAD;
        end
        urtp_pkg::PH_END: begin
          if (h >= 0 && n_end < MAX_DIGITS) begin
            last_acc = (last_acc << 4) | 32'(h[3:0]);
            n_end++;
          end else begin
            phase = urtp_pkg::PH_BAD;
          end
        end
        default: phase = urtp_pkg::PH_BAD;
      endcase
      if (!eot) return;
      ok = 1'b0;
      lo = '0;
      hi = '0;
      if (phase == urtp_pkg::PH_START && n_start > 0) begin
        lo = first_acc;
        hi = first_acc;
        ok = 1'b1;
      end else if (phase == urtp_pkg::PH_WILD) begin
        lo = first_acc << (4 * n_wild);
        hi = lo | ((32'd1 << (4 * n_wild)) - 32'd1);
        ok = 1'b1;
      end else if (phase == urtp_pkg::PH_END && n_end > 0) begin
        lo = first_acc;
        hi = last_acc;
        ok = 1'b1;
      end
      if (ok && (lo > hi || hi > 32'(urtp_pkg::MAX_CODE_POINT))) ok = 1'b0;
      w.legal    = ok;
      w.lo_point = ok ? lo[urtp_pkg::POINT_W-1:0] : '0;
      w.hi_point = ok ? hi[urtp_pkg::POINT_W-1:0] : '0;
      pending_ranges.push_back(w);
      restart();
    endfunction

    function void check_range(logic v, logic [urtp_pkg::POINT_W-1:0] f,
                              logic [urtp_pkg::POINT_W-1:0] l);
      range_word_t want;
      if (pending_ranges.size() == 0) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("%0t: range word with none expected: valid_res=%0b first=%h last=%h",
                   $time, v, f, l);
        end
        return;
      end
      want = pending_ranges.pop_front();
      n_checked++;
      if (want.legal) n_legal++;
      if (v !== want.legal || f !== want.lo_point || l !== want.hi_point) begin
        errors++;
        if (reported < 10) begin
          reported++;
          $display("%0t: range mismatch: valid_res exp %0b got %0b, first exp %h got %h, last exp %h got %h",
                   $time, want.legal, v, want.lo_point, f, want.hi_point, l);
        end
      end
    endfunction

    function int pending();
      return pending_ranges.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  urtp_char_if  text_ch();
  urtp_range_if res_ch();

  unicode_range_text_parser_unit #(
    .MAX_DIGITS (MAX_DIGITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_ch),
    .result (res_ch)
  );

  always #5 clk = ~clk;

  range_checker ranges = new();

  // sender side state
  logic [urtp_pkg::CHAR_W-1:0] text_buf[$];
  int   bytes_sent  = 0;
  int   texts_sent  = 0;
  int   pauses_done = 0;
  logic steady_send = 1'b0;  // no gaps between bytes while set

  // receiver side state
  logic hold_req   = 1'b0;
  int   hold_left  = 0;
  int   stall_left = 0;
  int   calm_left  = 0;
  int   holds_done = 0;

  initial begin
    text_ch.valid       = 1'b0;
    text_ch.ch          = '0;
    text_ch.end_of_text = 1'b0;
    res_ch.ready        = 1'b0;
  end

  // receiver: checks each taken range word, then picks ready for the next edge
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready)
        ranges.check_range(res_ch.valid_res, res_ch.range_first, res_ch.range_last);
      if (hold_req) begin
        // long hold-off so the result register fills and text.ready drops
        hold_req  <= 1'b0;
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else begin
        // now and then a calm stretch with ready held high throughout
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 199) == 0) calm_left = $urandom_range(50, 200);
        if (calm_left == 0 && $urandom_range(0, 99) < 25) begin
          // mostly short stalls, a few long ones
          stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                     : $urandom_range(9, 79);
          res_ch.ready <= 1'b0;
        end else begin
          res_ch.ready <= 1'b1;
        end
      end
    end
  end

  // watchdog: ends the run when no word has moved for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((text_ch.valid && text_ch.ready) || (res_ch.valid && res_ch.ready)) idle = 0;
      else idle++;
    end
    $display("no word moved for %0d cycles", STALL_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  // idle cycles before the next byte; valid only drops when a gap is taken
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (steady_send || r < 60) n = 0;
    else if (r < 90) n = $urandom_range(1, 3);
    else if (r < 98) n = $urandom_range(4, 10);
    else n = $urandom_range(20, 60);
    if (n > 0) begin
      text_ch.valid <= 1'b0;
      text_ch.ch    <= urtp_pkg::CHAR_W'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  // offer one byte and hold it until the parser takes it
  task automatic send_byte(logic [urtp_pkg::CHAR_W-1:0] c, logic eot);
    text_ch.valid       <= 1'b1;
    text_ch.ch          <= c;
    text_ch.end_of_text <= eot;
    do @(posedge clk); while (!text_ch.ready);
    ranges.take_char(c, eot);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++) begin
      sender_gap();
      send_byte(text_buf[i], i == text_buf.size() - 1);
    end
    text_buf.delete();
    texts_sent++;
  endtask

  // sender pauses until every range word it caused has been taken
  task automatic drain_results();
    text_ch.valid <= 1'b0;
    do @(posedge clk); while (ranges.pending() != 0);
    pauses_done++;
  endtask

  task automatic push_string(string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // hex digits of v, most significant first, each in a random case
  task automatic push_hex(int unsigned v, int n);
    int unsigned d;
    for (int i = n - 1; i >= 0; i--) begin
      d = (v >> (4 * i)) & 4'hF;
      if (d < 10) text_buf.push_back(urtp_pkg::CH_ZERO + urtp_pkg::CHAR_W'(d));
      else if ($urandom_range(0, 1))
        text_buf.push_back(urtp_pkg::CH_UPPER_A + urtp_pkg::CHAR_W'(d - 10));
      else text_buf.push_back(urtp_pkg::CH_LOWER_A + urtp_pkg::CHAR_W'(d - 10));
    end
  endtask

  task automatic push_rand_digits(int n);
    for (int i = 0; i < n; i++) push_hex($urandom_range(0, 15), 1);
  endtask

  function automatic int digits_for(int unsigned v);
    int n;
    n = 1;
    while (n < 8 && (v >> (4 * n)) != 0) n++;
    return n;
  endfunction

  // code point with weight on legal values and on the edges of the range
  function automatic int unsigned pick_point();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 32'h10FFFF);
    if (r < 65) return $urandom_range(0, 255);
    if (r < 75) return $urandom_range(32'h10FF00, 32'h10FFFF);
    if (r < 80) return $urandom_range(32'h110000, 32'h1100FF);
    return $urandom & 32'hFFFFFF;
  endfunction

  // well-formed range text with random content, leading zeros included
  task automatic push_range_text();
    int unsigned v1;
    int unsigned v2;
    v1 = pick_point();
    if (v1 <= 32'h10FFFF && $urandom_range(0, 99) < 65) begin
      v2 = ($urandom_range(0, 3) == 0) ? v1 : v1 + $urandom_range(0, 32'h10FFFF - v1);
    end else begin
      v2 = pick_point();
    end
    push_string("+");
    push_hex(v1, $urandom_range(digits_for(v1), MAX_DIGITS));
    push_string("-");
    push_hex(v2, $urandom_range(digits_for(v2), MAX_DIGITS));
  endtask

  task automatic make_random_text();
    int          kind;
    int          d;
    int          w;
    int unsigned v;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      // single code point
      v = pick_point();
      push_string("+");
      push_hex(v, $urandom_range(digits_for(v), MAX_DIGITS));
    end else if (kind < 45) begin
      // prefix digits then wildcards
      d = $urandom_range(0, MAX_DIGITS - 1);
      w = $urandom_range(1, MAX_DIGITS - d);
      if ($urandom_range(0, 1)) v = $urandom_range(0, 32'h10FFFF) >> (4 * w);
      else v = $urandom;
      v = v & ((32'd1 << (4 * d)) - 1);
      push_string("+");
      push_hex(v, d);
      repeat (w) push_string("?");
    end else if (kind < 75) begin
      push_range_text();
    end else if (kind < 80) begin
      // one or two digits or wildcards too many somewhere
      push_string("+");
      case ($urandom_range(0, 2))
        0: push_rand_digits($urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 2));
        1: begin
          d = $urandom_range(0, MAX_DIGITS);
          push_rand_digits(d);
          repeat ($urandom_range(MAX_DIGITS + 1 - d, MAX_DIGITS + 2 - d)) push_string("?");
        end
        default: begin
          push_rand_digits($urandom_range(1, MAX_DIGITS));
          push_string("-");
          push_rand_digits(MAX_DIGITS + 1);
        end
      endcase
    end else if (kind < 85) begin
      // dash with nothing after it
      push_string("+");
      push_rand_digits($urandom_range(1, MAX_DIGITS));
      push_string("-");
    end else if (kind < 90) begin
      case ($urandom_range(0, 3))
        0: push_string("+");
        1: push_string("+-");
        2: push_string("+?-");
        default: push_string("+??-1");
      endcase
    end else if (kind < 95) begin
      // legal text with one byte replaced by anything at all
      push_range_text();
      text_buf[$urandom_range(0, text_buf.size() - 1)] =
        urtp_pkg::CHAR_W'($urandom_range(0, 255));
    end else begin
      // raw noise, sometimes behind a plus sign
      if ($urandom_range(0, 1)) push_string("+");
      repeat ($urandom_range(1, 8))
        text_buf.push_back(urtp_pkg::CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_string(string s);
    push_string(s);
    send_text();
  endtask

  initial begin : stimulus
    int base;
    int steady_texts;
    logic held;
    logic paused;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed texts: extremes, every branch of the grammar, each failure kind
    send_string("+");          // bare plus
    send_string("+-");         // dash with no start digits
    send_string("+0");         // lowest code point
    send_string("+10FFFF");    // highest code point
    send_string("+110000");    // just above the top of the range
    send_string("+10????");    // wildcard reaching exactly the top
    send_string("+??????");    // all wildcards, end beyond the range
    send_string("+0000000");   // digit beyond the limit
    send_string("+a-");        // dash with no end digits
    send_string("+5-3");       // first above last
    send_string("+aB-cD");     // mixed case range
    send_string("+1x2");       // unexpected byte mid text
    send_string("Z");          // no plus sign at all
    drain_results();

    // random texts
    base         = bytes_sent;
    steady_texts = 0;
    held         = 1'b0;
    paused       = 1'b0;
    while (bytes_sent - base < RANDOM_ITEMS) begin
      if (!held && bytes_sent - base > RANDOM_ITEMS / 3) begin
        // receiver holds off while the sender keeps offering bytes back to back
        hold_req     <= 1'b1;
        held         = 1'b1;
        steady_send  = 1'b1;
        steady_texts = 40;
      end else if (!paused && bytes_sent - base > 2 * RANDOM_ITEMS / 3) begin
        drain_results();
        paused = 1'b1;
      end
      if (steady_texts > 0) steady_texts--;
      else if ($urandom_range(0, 24) == 0) steady_send = !steady_send;
      make_random_text();
      send_text();
    end
    text_ch.valid <= 1'b0;

    // wait for the last range words, then let the block settle
    while (ranges.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    ranges.errors += ranges.pending();

    $display("parsed %0d texts in %0d bytes: %0d range words checked, %0d legal, %0d rejected",
             texts_sent, bytes_sent, ranges.n_checked, ranges.n_legal,
             ranges.n_checked - ranges.n_legal);
    $display("receiver hold-offs %0d, drained pauses %0d, mismatches %0d",
             holds_done, pauses_done, ranges.errors);
    if (ranges.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/urtp_pkg.sv
rtl/urtp_char_if.sv
rtl/urtp_range_if.sv
rtl/unicode_range_text_parser_unit.sv
tb/testbench.sv
